>>> rtl/spt_pkg.sv
// shared types, codes and tables of the temperature sensor poll sequencer
// no dependencies; the modules in rtl refer to it by scoped names
package spt_pkg;

    // read lengths of the sensor transfers
    localparam int CALIB_BLOCK_LEN = 26;
    localparam int MEAS_BURST_LEN  = 8;
    localparam int HUM1_LEN        = 1;
    localparam int HUM26_LEN       = 7;

    // configuration port
    localparam int CFG_ADDR_W = 4;
    localparam logic [1:0] CFG_IDX_DEV_ADDR  = 2'd0;
    localparam logic [1:0] CFG_IDX_HUM_CTRL  = 2'd1;
    localparam logic [1:0] CFG_IDX_FILT_CFG  = 2'd2;
    localparam logic [1:0] CFG_IDX_MEAS_CTRL = 2'd3;

    localparam logic [6:0] DEV_ADDR_RST  = 7'h76;
    localparam logic [7:0] HUM_CTRL_RST  = 8'h01;
    localparam logic [7:0] FILT_CFG_RST  = 8'h00;
    localparam logic [7:0] MEAS_CTRL_RST = 8'h25;

    // sensor register addresses
    localparam logic [7:0] REG_CALIB     = 8'h88;
    localparam logic [7:0] REG_HUM1      = 8'hA1;
    localparam logic [7:0] REG_HUM26     = 8'hE1;
    localparam logic [7:0] REG_CTRL_HUM  = 8'hF2;
    localparam logic [7:0] REG_CONFIG    = 8'hF5;
    localparam logic [7:0] REG_CTRL_MEAS = 8'hF4;
    localparam logic [7:0] REG_BURST     = 8'hF7;

    // bus sequence codes, as reported on state_code
    localparam logic [4:0] ST_INIT      = 5'd0;
    localparam logic [4:0] ST_IDLE      = 5'd1;
    localparam logic [4:0] ST_CAL_PTR   = 5'd2;
    localparam logic [4:0] ST_CAL_RD    = 5'd3;
    localparam logic [4:0] ST_H1_PTR    = 5'd4;
    localparam logic [4:0] ST_H1_RD     = 5'd5;
    localparam logic [4:0] ST_H26_PTR   = 5'd6;
    localparam logic [4:0] ST_H26_RD    = 5'd7;
    localparam logic [4:0] ST_CAL_DONE  = 5'd8;
    localparam logic [4:0] ST_HUM_WR    = 5'd9;
    localparam logic [4:0] ST_HUM_WT    = 5'd10;
    localparam logic [4:0] ST_CFG_WR    = 5'd11;
    localparam logic [4:0] ST_CFG_WT    = 5'd12;
    localparam logic [4:0] ST_MEAS_WR   = 5'd13;
    localparam logic [4:0] ST_MEAS_WT   = 5'd14;
    localparam logic [4:0] ST_BURST_PTR = 5'd15;
    localparam logic [4:0] ST_BURST_RD  = 5'd16;

    // read targets
    localparam logic [1:0] TGT_NONE = 2'd0;
    localparam logic [1:0] TGT_CAL  = 2'd1;
    localparam logic [1:0] TGT_HUM  = 2'd2;
    localparam logic [1:0] TGT_MEAS = 2'd3;

    // request kinds
    localparam logic [1:0] KIND_PTR = 2'd0;
    localparam logic [1:0] KIND_WR  = 2'd1;
    localparam logic [1:0] KIND_RD  = 2'd2;

    // item actions
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_BYTE = 1'b1;

    typedef struct packed {
        logic [6:0] dev_addr;
        logic [7:0] hum_ctrl;
        logic [7:0] filt_cfg;
        logic [7:0] meas_ctrl;
    } cfg_t;

    typedef struct packed {
        logic       action;
        logic       i2c_busy;
        logic       i2c_accept;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [6:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] wr_data;
        logic [4:0] rx_len;
    } req_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [7:0] reg_addr;
        logic [7:0] wr_data;
        logic [4:0] rx_len;
        logic [1:0] tgt;
        logic [4:0] next;
    } seq_step_t;

    // stored calibration and raw measurement bytes, entry 0 in the low byte
    typedef struct packed {
        logic [5:0][7:0] calib;
        logic [2:0][7:0] raw;
    } meas_t;

    // microprogram
    localparam int UPC_W = 3;
    localparam logic [UPC_W-1:0] UPC_FETCH  = 3'd0;
    localparam logic [UPC_W-1:0] UPC_UPDATE = 3'd1;
    localparam logic [UPC_W-1:0] UPC_MUL_A  = 3'd2;
    localparam logic [UPC_W-1:0] UPC_MUL_D  = 3'd3;
    localparam logic [UPC_W-1:0] UPC_MUL_T3 = 3'd4;
    localparam logic [UPC_W-1:0] UPC_FINE   = 3'd5;
    localparam logic [UPC_W-1:0] UPC_EMIT   = 3'd6;

    typedef enum logic [1:0] {
        MUL_NONE  = 2'd0,
        MUL_A_T2  = 2'd1,
        MUL_D_D   = 2'd2,
        MUL_Q_T3  = 2'd3
    } mul_sel_t;

    typedef enum logic [1:0] {
        COND_ALWAYS = 2'd0,
        COND_IN     = 2'd1,
        COND_OUT    = 2'd2
    } cond_t;

    typedef struct packed {
        mul_sel_t         mul_sel;
        logic             upd;
        logic             ld_var1;
        logic             ld_fine;
        logic             emit;
        cond_t            cond;
        logic [UPC_W-1:0] target;
    } uop_t;

    // strobes from the sequencer to the datapath
    typedef struct packed {
        logic     take;
        logic     update;
        mul_sel_t mul_sel;
        logic     ld_var1;
        logic     ld_fine;
        logic     emit;
    } seq_ctl_t;

    // control store: a step stays put until its condition holds, then jumps
    function automatic uop_t uop_rom(input logic [UPC_W-1:0] upc);
        uop_t u;
        u = '{mul_sel: MUL_NONE, upd: 1'b0, ld_var1: 1'b0, ld_fine: 1'b0,
              emit: 1'b0, cond: COND_ALWAYS, target: UPC_FETCH};
        unique case (upc)
            UPC_FETCH:
            begin
                u.cond   = COND_IN;
                u.target = UPC_UPDATE;
            end
            UPC_UPDATE:
            begin
                u.upd    = 1'b1;
                u.target = UPC_MUL_A;
            end
            UPC_MUL_A:
            begin
                u.mul_sel = MUL_A_T2;
                u.target  = UPC_MUL_D;
            end
            UPC_MUL_D:
            begin
                u.mul_sel = MUL_D_D;
                u.ld_var1 = 1'b1;
                u.target  = UPC_MUL_T3;
            end
            UPC_MUL_T3:
            begin
                u.mul_sel = MUL_Q_T3;
                u.target  = UPC_FINE;
            end
            UPC_FINE:
            begin
                u.ld_fine = 1'b1;
                u.target  = UPC_EMIT;
            end
            UPC_EMIT:
            begin
                u.emit   = 1'b1;
                u.cond   = COND_OUT;
                u.target = UPC_FETCH;
            end
            default:
            begin
                u.target = UPC_FETCH;
            end
        endcase
        return u;
    endfunction

    // one tick of the bus sequence: request presented and state to go to
    function automatic seq_step_t seq_table(input logic [4:0] st, input logic busy,
                                            input cfg_t cfg);
        seq_step_t s;
        s = '0;
        s.next = st;
        unique case (st)
            ST_INIT:
            begin
                if (!busy)
                    s.next = ST_CAL_PTR;
            end
            ST_CAL_PTR:
            begin
                // presented without waiting for a free bus
                s.valid = 1'b1; s.kind = KIND_PTR; s.reg_addr = REG_CALIB;
                s.next = ST_CAL_RD;
            end
            ST_CAL_RD:
            begin
                if (!busy)
                begin
                    s.valid = 1'b1; s.kind = KIND_RD; s.rx_len = 5'(CALIB_BLOCK_LEN);
                    s.tgt = TGT_CAL; s.next = ST_H1_PTR;
                end
            end
            ST_H1_PTR:
            begin
                if (!busy)
                begin
                    s.valid = 1'b1; s.kind = KIND_PTR; s.reg_addr = REG_HUM1;
                    s.next = ST_H1_RD;
                end
            end
            ST_H1_RD:
            begin
                if (!busy)
                begin
                    s.valid = 1'b1; s.kind = KIND_RD; s.rx_len = 5'(HUM1_LEN);
                    s.tgt = TGT_HUM; s.next = ST_H26_PTR;
                end
            end
            ST_H26_PTR:
            begin
                if (!busy)
                begin
                    s.valid = 1'b1; s.kind = KIND_PTR; s.reg_addr = REG_HUM26;
                    s.next = ST_H26_RD;
                end
            end
            ST_H26_RD:
            begin
                if (!busy)
                begin
                    s.valid = 1'b1; s.kind = KIND_RD; s.rx_len = 5'(HUM26_LEN);
                    s.tgt = TGT_HUM; s.next = ST_CAL_DONE;
                end
            end
            ST_CAL_DONE:
            begin
                s.next = ST_HUM_WR;
            end
            ST_HUM_WR:
            begin
                if (!busy)
                begin
                    s.valid = 1'b1; s.kind = KIND_WR; s.reg_addr = REG_CTRL_HUM;
                    s.wr_data = cfg.hum_ctrl; s.next = ST_HUM_WT;
                end
            end
            ST_HUM_WT:
            begin
                if (!busy)
                    s.next = ST_CFG_WR;
            end
            ST_CFG_WR:
            begin
                if (!busy)
                begin
                    s.valid = 1'b1; s.kind = KIND_WR; s.reg_addr = REG_CONFIG;
                    s.wr_data = cfg.filt_cfg; s.next = ST_CFG_WT;
                end
            end
            ST_CFG_WT:
            begin
                if (!busy)
                    s.next = ST_MEAS_WR;
            end
            ST_MEAS_WR:
            begin
                if (!busy)
                begin
                    s.valid = 1'b1; s.kind = KIND_WR; s.reg_addr = REG_CTRL_MEAS;
                    s.wr_data = cfg.meas_ctrl; s.next = ST_MEAS_WT;
                end
            end
            ST_MEAS_WT:
            begin
                if (!busy)
                    s.next = ST_BURST_PTR;
            end
            ST_BURST_PTR:
            begin
                if (!busy)
                begin
                    s.valid = 1'b1; s.kind = KIND_PTR; s.reg_addr = REG_BURST;
                    s.next = ST_BURST_RD;
                end
            end
            ST_BURST_RD:
            begin
                if (!busy)
                begin
                    s.valid = 1'b1; s.kind = KIND_RD; s.rx_len = 5'(MEAS_BURST_LEN);
                    s.tgt = TGT_MEAS; s.next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s.next = ST_MEAS_WR;
            end
            default:
            begin
                s.next = ST_INIT;
            end
        endcase
        return s;
    endfunction

endpackage

>>> rtl/spt_item_if.sv
// input item channel of the poll sequencer: valid/ready plus the item fields
// depends on nothing
interface spt_item_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic       i2c_busy;
    logic       i2c_accept;
    logic [7:0] rx_byte;

    modport source (output valid, output action, output i2c_busy, output i2c_accept,
                    output rx_byte, input ready);
    modport sink   (input valid, input action, input i2c_busy, input i2c_accept,
                    input rx_byte, output ready);
endinterface

>>> rtl/spt_result_if.sv
// result channel of the poll sequencer: valid/ready plus the result fields
// depends on nothing
interface spt_result_if;
    logic               valid;
    logic               ready;
    logic               req_valid;
    logic [1:0]         req_kind;
    logic [6:0]         dev_addr;
    logic [7:0]         reg_addr;
    logic [7:0]         wr_data;
    logic [4:0]         rx_len;
    logic [4:0]         state_code;
    logic               temp_valid;
    logic signed [31:0] temperature;

    modport source (output valid, output req_valid, output req_kind, output dev_addr,
                    output reg_addr, output wr_data, output rx_len, output state_code,
                    output temp_valid, output temperature, input ready);
    modport sink   (input valid, input req_valid, input req_kind, input dev_addr,
                    input reg_addr, input wr_data, input rx_len, input state_code,
                    input temp_valid, input temperature, output ready);
endinterface

>>> rtl/spt_cfg_regs.sv
// apb-style configuration registers of the poll sequencer
// depends on spt_pkg for the register indexes, reset values and cfg_t
module spt_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [spt_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output spt_pkg::cfg_t                  cfg
);

    spt_pkg::cfg_t cfg_reg;
    spt_pkg::cfg_t cfg_next;
    logic [1:0]    idx;
    logic          wr_en;

    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                spt_pkg::CFG_IDX_DEV_ADDR:  cfg_next.dev_addr  = pwdata[6:0];
                spt_pkg::CFG_IDX_HUM_CTRL:  cfg_next.hum_ctrl  = pwdata[7:0];
                spt_pkg::CFG_IDX_FILT_CFG:  cfg_next.filt_cfg  = pwdata[7:0];
                spt_pkg::CFG_IDX_MEAS_CTRL: cfg_next.meas_ctrl = pwdata[7:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            spt_pkg::CFG_IDX_DEV_ADDR:  prdata = {25'd0, cfg_reg.dev_addr};
            spt_pkg::CFG_IDX_HUM_CTRL:  prdata = {24'd0, cfg_reg.hum_ctrl};
            spt_pkg::CFG_IDX_FILT_CFG:  prdata = {24'd0, cfg_reg.filt_cfg};
            spt_pkg::CFG_IDX_MEAS_CTRL: prdata = {24'd0, cfg_reg.meas_ctrl};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dev_addr  <= spt_pkg::DEV_ADDR_RST;
            cfg_reg.hum_ctrl  <= spt_pkg::HUM_CTRL_RST;
            cfg_reg.filt_cfg  <= spt_pkg::FILT_CFG_RST;
            cfg_reg.meas_ctrl <= spt_pkg::MEAS_CTRL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> rtl/spt_useq.sv
// microprogram sequencer: step counter, control store lookup, conditional jumps
// depends on spt_pkg for the control word, the control store and seq_ctl_t
module spt_useq (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      out_free,
    output logic                      in_ready,
    output spt_pkg::seq_ctl_t         ctl,
    output logic [spt_pkg::UPC_W-1:0] upc
);

    logic [spt_pkg::UPC_W-1:0] upc_reg;
    logic [spt_pkg::UPC_W-1:0] upc_next;
    spt_pkg::uop_t             uop;
    logic                      cond_ok;

    assign uop = spt_pkg::uop_rom(upc_reg);
    assign upc = upc_reg;

    always_comb
    begin
        unique case (uop.cond)
            spt_pkg::COND_ALWAYS: cond_ok = 1'b1;
            spt_pkg::COND_IN:     cond_ok = in_valid;
            spt_pkg::COND_OUT:    cond_ok = out_free;
            default:              cond_ok = 1'b0;
        endcase
    end

    assign upc_next = cond_ok ? uop.target : upc_reg;
    assign in_ready = (uop.cond == spt_pkg::COND_IN);

    always_comb
    begin
        ctl.take    = in_ready && in_valid;
        ctl.update  = uop.upd;
        ctl.mul_sel = uop.mul_sel;
        ctl.ld_var1 = uop.ld_var1;
        ctl.ld_fine = uop.ld_fine;
        ctl.emit    = uop.emit && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            upc_reg <= spt_pkg::UPC_FETCH;
        else
            upc_reg <= upc_next;
    end

endmodule

>>> rtl/spt_link.sv
// bus sequence and receive side: sequence state, read target, byte count,
// stored calibration and raw temperature bytes; depends on spt_pkg
module spt_link (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               update,
    input  spt_pkg::item_t     item,
    input  spt_pkg::cfg_t      cfg,
    output spt_pkg::req_t      req,
    output logic [4:0]         state_code,
    output logic               meas_seen,
    output spt_pkg::meas_t     meas
);

    logic [4:0]      state_reg, state_next;
    logic [1:0]      tgt_reg, tgt_next;
    logic [4:0]      count_reg, count_next;
    logic            seen_reg, seen_next;
    spt_pkg::req_t   req_reg, req_next;
    logic [5:0][7:0] calib_reg;
    logic [2:0][7:0] raw_reg;

    spt_pkg::seq_step_t step;
    logic [5:0]         cnt_inc;
    logic [5:0]         rd_len;
    logic               last_byte;
    logic               calib_we;
    logic               raw_we;
    logic [1:0]         raw_idx;
    logic [4:0]         raw_off;

    assign step      = spt_pkg::seq_table(state_reg, item.i2c_busy, cfg);
    assign cnt_inc   = {1'b0, count_reg} + 6'd1;
    assign rd_len    = (tgt_reg == spt_pkg::TGT_CAL) ? 6'(spt_pkg::CALIB_BLOCK_LEN)
                                                     : 6'(spt_pkg::MEAS_BURST_LEN);
    assign last_byte = (cnt_inc >= rd_len);
    assign raw_off   = count_reg - 5'd3;
    assign raw_idx   = raw_off[1:0];

    always_comb
    begin
        state_next = state_reg;
        tgt_next   = tgt_reg;
        count_next = count_reg;
        seen_next  = seen_reg;
        req_next   = req_reg;
        calib_we   = 1'b0;
        raw_we     = 1'b0;
        if (update)
        begin
            req_next = '0;
            if (item.action == spt_pkg::ACT_TICK)
            begin
                req_next.valid    = step.valid;
                req_next.kind     = step.kind;
                req_next.dev_addr = step.valid ? cfg.dev_addr : 7'd0;
                req_next.reg_addr = step.reg_addr;
                req_next.wr_data  = step.wr_data;
                req_next.rx_len   = step.rx_len;
                // a presented request moves on only once the bus takes it
                if (!step.valid || item.i2c_accept)
                    state_next = step.next;
                if (step.valid && item.i2c_accept && step.kind == spt_pkg::KIND_RD)
                begin
                    tgt_next   = step.tgt;
                    count_next = 5'd0;
                end
            end
            else
            begin
                priority if (tgt_reg == spt_pkg::TGT_NONE)
                begin
                    // stray beat with no read open
                end
                else if (tgt_reg == spt_pkg::TGT_HUM)
                begin
                    if (count_reg != 5'd31)
                        count_next = count_reg + 5'd1;
                end
                else
                begin
                    if (tgt_reg == spt_pkg::TGT_CAL)
                        calib_we = (count_reg < 5'd6);
                    else
                        raw_we = (count_reg >= 5'd3) && (count_reg < 5'd6);
                    if (last_byte)
                    begin
                        if (tgt_reg == spt_pkg::TGT_MEAS)
                            seen_next = 1'b1;
                        tgt_next   = spt_pkg::TGT_NONE;
                        count_next = 5'd0;
                    end
                    else
                    begin
                        count_next = cnt_inc[4:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spt_pkg::ST_INIT;
            tgt_reg   <= spt_pkg::TGT_NONE;
            count_reg <= 5'd0;
            seen_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tgt_reg   <= tgt_next;
            count_reg <= count_next;
            seen_reg  <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        if (calib_we)
            calib_reg[count_reg[2:0]] <= item.rx_byte;
        if (raw_we)
            raw_reg[raw_idx] <= item.rx_byte;
    end

    assign req        = req_reg;
    assign state_code = state_reg;
    assign meas_seen  = seen_reg;
    assign meas.calib = calib_reg;
    assign meas.raw   = raw_reg;

endmodule

>>> rtl/spt_comp_dp.sv
// temperature compensation datapath: one shared 32x32 multiplier, wrapping
// 32-bit arithmetic, stepped by the microprogram; depends on spt_pkg
module spt_comp_dp (
    input  logic                clk,
    input  spt_pkg::seq_ctl_t   ctl,
    input  spt_pkg::meas_t      meas,
    output logic signed [31:0]  temperature
);

    logic [19:0] adc;
    logic [15:0] t1;
    logic [31:0] t2, t3;
    logic [31:0] a_term, d_term;
    logic [31:0] op_a, op_b;
    logic [31:0] prod_reg, prod_next;
    logic [31:0] var1_reg;
    logic [31:0] fine_reg;
    logic [31:0] q_term;
    logic [31:0] var2;
    logic [31:0] fine5;

    assign adc = {meas.raw[0], meas.raw[1], meas.raw[2][7:4]};
    assign t1  = {meas.calib[1], meas.calib[0]};
    assign t2  = {{16{meas.calib[3][7]}}, meas.calib[3], meas.calib[2]};
    assign t3  = {{16{meas.calib[5][7]}}, meas.calib[5], meas.calib[4]};

    assign a_term = {15'd0, adc[19:3]} - {15'd0, t1, 1'b0};
    assign d_term = {16'd0, adc[19:4]} - {16'd0, t1};
    assign q_term = 32'($signed(prod_reg) >>> 12);
    assign var2   = 32'($signed(prod_reg) >>> 14);

    always_comb
    begin
        unique case (ctl.mul_sel)
            spt_pkg::MUL_A_T2:
            begin
                op_a = a_term;
                op_b = t2;
            end
            spt_pkg::MUL_D_D:
            begin
                op_a = d_term;
                op_b = d_term;
            end
            spt_pkg::MUL_Q_T3:
            begin
                op_a = q_term;
                op_b = t3;
            end
            default:
            begin
                op_a = 32'd0;
                op_b = 32'd0;
            end
        endcase
    end

    // low half of the product only, so signedness does not matter
    assign prod_next = 32'(op_a * op_b);

    always_ff @(posedge clk)
    begin
        if (ctl.mul_sel != spt_pkg::MUL_NONE)
            prod_reg <= prod_next;
        if (ctl.ld_var1)
            var1_reg <= 32'($signed(prod_reg) >>> 11);
        if (ctl.ld_fine)
            fine_reg <= var1_reg + var2;
    end

    // fine * 5 + 128, then arithmetic shift by eight
    assign fine5       = fine_reg + {fine_reg[29:0], 2'b00} + 32'd128;
    assign temperature = $signed(fine5) >>> 8;

endmodule

>>> rtl/sensor_poll_temp_compensator_unit.sv
// top level of the temperature sensor poll sequencer with compensation
// depends on spt_pkg, spt_item_if, spt_result_if, spt_cfg_regs, spt_useq,
// spt_link and spt_comp_dp
//
// Each input beat (a tick or one received bus byte) yields exactly one result
// beat carrying the bus request presented on that tick, the sequence state
// afterwards and the compensated temperature in 0.01 C (zero until the first
// measurement burst has arrived). The microprogram takes no new item until
// the result of the current one is loaded, and it walks the shared 32x32
// multiplier three times for each compensation. A new item is taken while
// the previous result still waits in the output register; the sequencer
// holds on its final step only if that register is still full. Nothing
// needs clearing after reset.
// Registers (apb, 32-bit data): 0x0 device address, 0x4 humidity control
// byte, 0x8 filter config byte, 0xc measurement control byte; write them
// only while no item is in flight.
module sensor_poll_temp_compensator_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    spt_item_if.sink                       item,
    spt_result_if.source                   result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [spt_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    spt_pkg::cfg_t             cfg;
    spt_pkg::seq_ctl_t         ctl;
    spt_pkg::item_t            item_reg;
    spt_pkg::req_t             req;
    spt_pkg::meas_t            meas;
    logic [4:0]                state_code;
    logic                      meas_seen;
    logic signed [31:0]        temp;
    logic                      out_free;
    logic [spt_pkg::UPC_W-1:0] upc;

    logic               out_valid_reg, out_valid_next;
    spt_pkg::req_t      out_req_reg;
    logic [4:0]         out_state_reg;
    logic               out_tvalid_reg;
    logic signed [31:0] out_temp_reg;

    assign out_free = !out_valid_reg || result.ready;

    spt_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    spt_useq u_useq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .out_free (out_free),
        .in_ready (item.ready),
        .ctl      (ctl),
        .upc      (upc)
    );

    spt_link u_link (
        .clk        (clk),
        .rst_n      (rst_n),
        .update     (ctl.update),
        .item       (item_reg),
        .cfg        (cfg),
        .req        (req),
        .state_code (state_code),
        .meas_seen  (meas_seen),
        .meas       (meas)
    );

    spt_comp_dp u_dp (
        .clk         (clk),
        .ctl         (ctl),
        .meas        (meas),
        .temperature (temp)
    );

    // input beat latch
    always_ff @(posedge clk)
    begin
        if (ctl.take)
        begin
            item_reg.action     <= item.action;
            item_reg.i2c_busy   <= item.i2c_busy;
            item_reg.i2c_accept <= item.i2c_accept;
            item_reg.rx_byte    <= item.rx_byte;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.emit)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            out_req_reg    <= req;
            out_state_reg  <= state_code;
            out_tvalid_reg <= meas_seen;
            out_temp_reg   <= meas_seen ? temp : 32'sd0;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.req_valid   = out_req_reg.valid;
    assign result.req_kind    = out_req_reg.kind;
    assign result.dev_addr    = out_req_reg.dev_addr;
    assign result.reg_addr    = out_req_reg.reg_addr;
    assign result.wr_data     = out_req_reg.wr_data;
    assign result.rx_len      = out_req_reg.rx_len;
    assign result.state_code  = out_state_reg;
    assign result.temp_valid  = out_tvalid_reg;
    assign result.temperature = out_temp_reg;

`ifndef ASSERT_OFF
    // one beat in, then the microprogram runs before the next is taken
    a_take_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready |=> !item.ready)
        else $error("input taken twice in a row");

    // a result appears only from the final microprogram step
    a_emit_from_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(upc) == spt_pkg::UPC_EMIT)
        else $error("result loaded outside the final step");

    a_temp_zero_before_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.temp_valid |-> result.temperature == 32'sd0)
        else $error("temperature not zero before first burst");

    a_no_request_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.req_valid |->
            result.req_kind == spt_pkg::KIND_PTR && result.dev_addr == 7'd0 &&
            result.reg_addr == 8'd0 && result.rx_len == 5'd0)
        else $error("request fields set without a request");
`endif

endmodule
